### design/dfa_acc_pkg.sv
// Shared types and constants for the table-driven DFA acceptor.
// Holds field widths, the action codes, register indexes and the store entry format.
// No dependencies; the store, step and top-level files import this package.
package dfa_acc_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_NUM_STATES = 16;
    localparam int DEF_COUNT_BITS = 16;

    // Field widths fixed by the item formats.
    localparam int SYM_W      = 8;
    localparam int ID_W       = 4;
    localparam int CONSUMED_W = 16;
    localparam int MASK_W     = 16;

    // Port widths.
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Request kinds carried on the input stream.
    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_START  = 2'd1,
        ACT_SYMBOL = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 1'b1;

    typedef logic [ID_W-1:0]  t_state_id;
    typedef logic [SYM_W-1:0] t_symbol;

    // One transition store entry.
    typedef struct packed {
        logic      valid;
        t_state_id target;
    } t_entry;

    // Read request into the transition store.
    typedef struct packed {
        logic      en;
        t_state_id state;
        t_symbol   sym;
    } t_lookup;

    // Write request into the transition store.
    typedef struct packed {
        logic      en;
        t_state_id state;
        t_symbol   sym;
        t_entry    entry;
    } t_update;

endpackage

### design/dfa_acc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters; no package dependencies.
module dfa_acc_ram #(
    parameter int  WIDTH  = 5,
    parameter int  DEPTH  = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/dfa_acc_store.sv
// Transition store: RAM of (state, symbol) entries, range checks and the clearing sweep.
// Depends on dfa_acc_pkg and dfa_acc_ram.
module dfa_acc_store #(
    parameter int NUM_STATES = dfa_acc_pkg::DEF_NUM_STATES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dfa_acc_pkg::t_lookup i_lookup,
    input  dfa_acc_pkg::t_update i_update,
    output dfa_acc_pkg::t_entry  o_entry,
    output logic                 o_busy
);
    import dfa_acc_pkg::*;

    localparam int DEPTH  = NUM_STATES * (1 << SYM_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ST_W   = ADDR_W - SYM_W;
    localparam int NS_W   = $clog2(NUM_STATES + 1);
    localparam int CMP_W  = (NS_W > ID_W) ? NS_W : ID_W;
    localparam logic [CMP_W-1:0]  NS_LIMIT = CMP_W'(NUM_STATES);
    localparam logic [ADDR_W-1:0] LAST     = ADDR_W'(DEPTH - 1);

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_lk_in_range;
    logic              lk_in_range;
    logic              wr_in_range;
    logic [ADDR_W-1:0] lk_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;

    // Address forming and state range checks.
    assign lk_in_range = CMP_W'(i_lookup.state) < NS_LIMIT;
    assign wr_in_range = CMP_W'(i_update.state) < NS_LIMIT;
    assign lk_addr     = {ST_W'(i_lookup.state), i_lookup.sym};
    assign wr_addr     = {ST_W'(i_update.state), i_update.sym};

    // The clearing sweep owns the write port until every entry is invalid.
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_update.en & wr_in_range;
            ram_waddr = wr_addr;
            ram_wdata = i_update.entry;
        end
    end

    // Clearing sweep counter, one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // A lookup from a state outside the table reads as a missing entry.
    always_ff @(posedge i_clk) begin
        if (i_lookup.en) begin
            r_lk_in_range <= lk_in_range;
        end
    end

    dfa_acc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_lookup.en),
        .i_raddr (lk_addr),
        .o_rdata (ram_rdata)
    );

    assign o_entry.valid  = ram_rdata.valid & r_lk_in_range;
    assign o_entry.target = ram_rdata.target;
    assign o_busy         = r_clr_busy;

endmodule

### design/dfa_acc_step.sv
// Automaton stage: applies one request per cycle, unless an end request waits on the
// result register, to the state, count and stop flag, and holds the result register. Depends on dfa_acc_pkg.
module dfa_acc_step #(
    parameter int COUNT_BITS = dfa_acc_pkg::DEF_COUNT_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_take,
    input  dfa_acc_pkg::t_action                  i_action,
    input  dfa_acc_pkg::t_entry                   i_entry,
    input  dfa_acc_pkg::t_state_id                i_start_state,
    input  logic [dfa_acc_pkg::MASK_W-1:0]        i_accept_mask,
    input  logic                                  i_m_ready,
    output dfa_acc_pkg::t_state_id                o_lookup_state,
    output logic                                  o_ready,
    output logic                                  o_m_valid,
    output logic                                  o_accepted,
    output logic [dfa_acc_pkg::CONSUMED_W-1:0]    o_consumed,
    output dfa_acc_pkg::t_state_id                o_final_state
);
    import dfa_acc_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  r_s1_valid;
    t_action               r_s1_action;
    t_state_id             r_state;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_stopped;
    logic                  r_out_valid;
    logic                  r_out_accepted;
    logic [CONSUMED_W-1:0] r_out_consumed;
    t_state_id             r_out_state;

    t_state_id             n_state;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_stopped;
    logic                  out_free;
    logic                  s1_adv;
    logic                  s1_end;

    // Stage handshake: only an end request waits on the result register.
    assign out_free = ~r_out_valid | i_m_ready;
    assign s1_end   = r_s1_action == ACT_END;
    assign s1_adv   = r_s1_valid & (~s1_end | out_free);
    assign o_ready  = ~r_s1_valid | s1_adv;

    // Next automaton state for the request held in the stage.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_stopped = r_stopped;
        if (s1_adv) begin
            unique case (r_s1_action)
                ACT_START: begin
                    n_state   = i_start_state;
                    n_count   = '0;
                    n_stopped = 1'b0;
                end
                ACT_SYMBOL: begin
                    if (!r_stopped) begin
                        if (i_entry.valid) begin
                            n_state = i_entry.target;
                            if (r_count != CNT_MAX) begin
                                n_count = r_count + 1'b1;
                            end
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                end
                ACT_WRITE, ACT_END: begin
                end
            endcase
        end
    end

    // The following symbol looks up from the state this request leaves.
    assign o_lookup_state = n_state;

    // Stage and automaton registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_state    <= '0;
            r_count    <= '0;
            r_stopped  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_take;
            end
            r_state   <= n_state;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1_action <= i_action;
        end
    end

    // Result register, loaded by an end request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_end) begin
            r_out_accepted <= ~r_stopped & i_accept_mask[r_state];
            r_out_consumed <= CONSUMED_W'(r_count);
            r_out_state    <= r_state;
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_accepted    = r_out_accepted;
    assign o_consumed    = r_out_consumed;
    assign o_final_state = r_out_state;

endmodule

### design/table_driven_dfa_acceptor_core.sv
// Top level of the table-driven DFA acceptor: stream ports, configuration registers,
// and the connection of the transition store to the automaton stage.
// Depends on dfa_acc_pkg, dfa_acc_store and dfa_acc_step.
//
//   Channel   Direction  Carries
//   s_axis    in         tuser = action; tdata = source_state, symbol, target_state, entry_valid
//   m_axis    out        tdata = accepted, consumed, final_state (one per end request)
//   cfg       in         write enable, register index, write data (start_state, accepting_mask)
//
// One request is taken per cycle unless clearing runs or an end request waits. A symbol
// is one read of the transition RAM; its read data selects the address of the next
// symbol's read, which sets the one-cycle rate. An end request loads the result register
// from the stage. After reset a clearing pass writes all NUM_STATES*256 entries (4096 by
// default) invalid with s_axis_tready low. An unserved result holds an end request in the
// stage and s_axis_tready stays low behind it; other requests never wait on m_axis.
module table_driven_dfa_acceptor_core #(
    parameter int NUM_STATES = dfa_acc_pkg::DEF_NUM_STATES,
    parameter int COUNT_BITS = dfa_acc_pkg::DEF_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: source_state[3:0], symbol[11:4], target_state[15:12], entry_valid[16]
    input  logic [dfa_acc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: action[1:0]
    input  logic [dfa_acc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: accepted[0], consumed[16:1], final_state[20:17]
    output logic [dfa_acc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [dfa_acc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dfa_acc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import dfa_acc_pkg::*;

    t_state_id             r_start_state;
    logic [MASK_W-1:0]     r_accept_mask;

    logic                  take;
    t_action               in_action;
    t_lookup               lookup;
    t_update               update;
    t_entry                entry;
    logic                  store_busy;
    logic                  step_ready;
    t_state_id             lookup_state;
    logic                  out_accepted;
    logic [CONSUMED_W-1:0] out_consumed;
    t_state_id             out_state;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_accept_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_STATE: r_start_state <= i_cfg_wdata[ID_W-1:0];
                REG_ACCEPT_MASK: r_accept_mask <= i_cfg_wdata[MASK_W-1:0];
            endcase
        end
    end

    // Input handshake and field unpacking.
    assign s_axis_tready = ~store_busy & step_ready;
    assign take          = s_axis_tvalid & s_axis_tready;
    assign in_action     = t_action'(s_axis_tuser);

    assign lookup.en    = take & (in_action == ACT_SYMBOL);
    assign lookup.state = lookup_state;
    assign lookup.sym   = s_axis_tdata[11:4];

    assign update.en           = take & (in_action == ACT_WRITE);
    assign update.state        = s_axis_tdata[3:0];
    assign update.sym          = s_axis_tdata[11:4];
    assign update.entry.target = s_axis_tdata[15:12];
    assign update.entry.valid  = s_axis_tdata[16];

    dfa_acc_store #(
        .NUM_STATES (NUM_STATES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (lookup),
        .i_update (update),
        .o_entry  (entry),
        .o_busy   (store_busy)
    );

    dfa_acc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_action       (in_action),
        .i_entry        (entry),
        .i_start_state  (r_start_state),
        .i_accept_mask  (r_accept_mask),
        .i_m_ready      (m_axis_tready),
        .o_lookup_state (lookup_state),
        .o_ready        (step_ready),
        .o_m_valid      (m_axis_tvalid),
        .o_accepted     (out_accepted),
        .o_consumed     (out_consumed),
        .o_final_state  (out_state)
    );

    // Result packing, padded to whole bytes.
    assign m_axis_tdata = {3'b000, out_state, out_consumed, out_accepted};

endmodule
